// ===== hw/rtl/vltp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vltp_pkg
// Shared types, character codes and sizes for the view layout text parser.
// ----------------------------------------------------------------------------
package vltp_pkg;

  // Width of every numeric result field
  localparam int OUT_W = 16;

  // Default width of numbers and counters inside the parser
  localparam int VALUE_BITS_DEF = 16;

  // Entries in the queue between the front and back parts
  localparam int QUEUE_DEPTH = 2;

  // Characters of the layout grammar
  localparam logic [7:0] CH_X     = 8'h78;  // 'x'
  localparam logic [7:0] CH_N     = 8'h4E;  // 'N'
  localparam logic [7:0] CH_PLUS  = 8'h2B;  // '+'
  localparam logic [7:0] CH_SPACE = 8'h20;  // ' '
  localparam logic [7:0] CH_NL    = 8'h0A;  // newline
  localparam logic [7:0] CH_0     = 8'h30;  // '0'
  localparam logic [7:0] CH_9     = 8'h39;  // '9'

  // Parser phases
  typedef enum logic [2:0] {
    PH_HDR_W = 3'd0,
    PH_HDR_H = 3'd1,
    PH_LINE  = 3'd2,
    PH_LABEL = 3'd3,
    PH_VX    = 3'd4,
    PH_VY    = 3'd5,
    PH_VW    = 3'd6,
    PH_VH    = 3'd7
  } phase_e;

  // Record kinds
  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_VIEW   = 2'd1,
    KIND_DONE   = 2'd2,
    KIND_ERROR  = 2'd3
  } kind_e;

  // Syntax error codes (what was expected)
  typedef enum logic [2:0] {
    ERR_NUMBER  = 3'd0,
    ERR_X       = 3'd1,
    ERR_NEWLINE = 3'd2,
    ERR_N       = 3'd3,
    ERR_SPACE   = 3'd4,
    ERR_PLUS    = 3'd5
  } err_e;

  // One result record
  typedef struct packed {
    kind_e            kind;
    logic [OUT_W-1:0] ordinal;
    logic [OUT_W-1:0] pos_x;
    logic [OUT_W-1:0] pos_y;
    logic [OUT_W-1:0] width;
    logic [OUT_W-1:0] height;
    logic             mismatch;
    err_e             code;
    logic [OUT_W-1:0] line;
    logic [OUT_W-1:0] column;
  } rec_t;

  // Everything one request produces: one or two records
  typedef struct packed {
    rec_t first;
    rec_t second;
    logic two;
  } entry_t;

  // Queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/vltp_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vltp_front
// Accepts one byte request per cycle when accept_i is set, runs the grammar
// state machine and pushes that request's records to the queue as one entry.
// ----------------------------------------------------------------------------
module vltp_front #(
  parameter int VALUE_BITS = vltp_pkg::VALUE_BITS_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             accept_i,
  input  wire logic [7:0]       data_byte_i,
  input  wire logic             text_end_i,
  input  wire logic             restart_i,
  output logic                  push_o,
  output vltp_pkg::entry_t      entry_o
);
  import vltp_pkg::*;

  localparam int ACC_W = VALUE_BITS + 4;
  localparam logic [VALUE_BITS-1:0] VMAX = '1;

  // Saturating increment
  function automatic logic [VALUE_BITS-1:0] sat_inc(input logic [VALUE_BITS-1:0] v);
    sat_inc = (v == VMAX) ? v : v + 1'b1;
  endfunction

  // Error record at a given position
  function automatic rec_t mk_err(input err_e code, input logic [VALUE_BITS-1:0] ln,
                                  input logic [VALUE_BITS-1:0] col);
    rec_t r;
    r        = '0;
    r.kind   = KIND_ERROR;
    r.code   = code;
    r.line   = OUT_W'(ln);
    r.column = OUT_W'(col);
    mk_err   = r;
  endfunction

  // Parser state
  phase_e                ph_q, ph_d;
  logic [VALUE_BITS-1:0] acc_q, acc_d;
  logic                  seen_q, seen_d;
  logic [VALUE_BITS-1:0] line_q, line_d;
  logic [VALUE_BITS-1:0] col_q, col_d;
  logic [VALUE_BITS-1:0] vc_q, vc_d;
  logic [VALUE_BITS-1:0] h1_q, h1_d;
  logic [VALUE_BITS-1:0] h2_q, h2_d;
  logic [VALUE_BITS-1:0] h3_q, h3_d;
  logic [VALUE_BITS-1:0] hl_q, hl_d;
  logic                  fin_q, fin_d;

  // State as seen by this request (restart applies first)
  phase_e                eff_ph;
  logic [VALUE_BITS-1:0] eff_acc, eff_line, eff_col, eff_vc;
  logic                  eff_seen, eff_fin;

  assign eff_ph   = restart_i ? PH_HDR_W : ph_q;
  assign eff_acc  = restart_i ? '0 : acc_q;
  assign eff_seen = restart_i ? 1'b0 : seen_q;
  assign eff_line = restart_i ? VALUE_BITS'(1) : line_q;
  assign eff_col  = restart_i ? VALUE_BITS'(1) : col_q;
  assign eff_vc   = restart_i ? VALUE_BITS'(1) : vc_q;
  assign eff_fin  = restart_i ? 1'b0 : fin_q;

  // Byte classification
  logic is_digit, is_nl;
  assign is_digit = !text_end_i && (data_byte_i inside {[CH_0:CH_9]});
  assign is_nl    = !text_end_i && (data_byte_i == CH_NL);

  // Decimal accumulate: acc*10 + digit, saturating
  logic [ACC_W-1:0]      acc_ext;
  logic [VALUE_BITS-1:0] acc_sat;
  assign acc_ext = (ACC_W'(eff_acc) << 3) + (ACC_W'(eff_acc) << 1)
                 + ACC_W'(data_byte_i - CH_0);
  assign acc_sat = (acc_ext > ACC_W'(VMAX)) ? VMAX : acc_ext[VALUE_BITS-1:0];

  // Position after this byte is consumed
  logic [VALUE_BITS-1:0] line_c, col_c;
  assign line_c = is_nl ? sat_inc(eff_line) : eff_line;
  assign col_c  = is_nl ? '0 : sat_inc(eff_col);

  // Separator expected after the number of each phase
  logic [7:0] sep_want;
  err_e       sep_code;
  phase_e     sep_next;
  logic       sep_ok;

  always_comb begin
    case (eff_ph)
      PH_HDR_W: begin
        sep_want = CH_X;     sep_code = ERR_X;     sep_next = PH_HDR_H;
      end
      PH_LABEL: begin
        sep_want = CH_SPACE; sep_code = ERR_SPACE; sep_next = PH_VX;
      end
      PH_VX: begin
        sep_want = CH_X;     sep_code = ERR_X;     sep_next = PH_VY;
      end
      PH_VY: begin
        sep_want = CH_PLUS;  sep_code = ERR_PLUS;  sep_next = PH_VW;
      end
      PH_VW: begin
        sep_want = CH_PLUS;  sep_code = ERR_PLUS;  sep_next = PH_VH;
      end
      default: begin
        sep_want = CH_NL;    sep_code = ERR_NEWLINE; sep_next = PH_LINE;
      end
    endcase
  end

  assign sep_ok = !text_end_i && (data_byte_i == sep_want);

  // Next state
  always_comb begin
    ph_d   = eff_ph;
    acc_d  = eff_acc;
    seen_d = eff_seen;
    line_d = eff_line;
    col_d  = eff_col;
    vc_d   = eff_vc;
    h1_d   = h1_q;
    h2_d   = h2_q;
    h3_d   = h3_q;
    hl_d   = hl_q;
    fin_d  = eff_fin;
    if (!eff_fin) begin
      if (eff_ph == PH_LINE) begin
        acc_d  = '0;
        seen_d = 1'b0;
        if (text_end_i) begin
          fin_d = 1'b1;
        end else begin
          line_d = line_c;
          col_d  = col_c;
          if (data_byte_i == CH_N) begin
            ph_d = PH_LABEL;
          end else begin
            fin_d = 1'b1;
          end
        end
      end else if (is_digit) begin
        acc_d  = acc_sat;
        seen_d = 1'b1;
        line_d = line_c;
        col_d  = col_c;
      end else if (!eff_seen) begin
        fin_d = 1'b1;
      end else begin
        acc_d  = '0;
        seen_d = 1'b0;
        case (eff_ph)
          PH_HDR_W: h1_d = eff_acc;
          PH_LABEL: hl_d = eff_acc;
          PH_VX:    h1_d = eff_acc;
          PH_VY:    h2_d = eff_acc;
          PH_VW:    h3_d = eff_acc;
          PH_VH:    vc_d = sat_inc(eff_vc);
          default:  ;
        endcase
        if ((eff_ph == PH_HDR_H || eff_ph == PH_VH) && text_end_i) begin
          fin_d = 1'b1;
        end else begin
          line_d = line_c;
          col_d  = col_c;
          if (sep_ok) begin
            ph_d = sep_next;
          end else begin
            fin_d = 1'b1;
          end
        end
      end
    end
  end

  // Records produced by this request, pushed only when it is accepted
  always_comb begin
    push_o  = 1'b0;
    entry_o = '0;
    if (accept_i && !eff_fin) begin
      if (eff_ph == PH_LINE) begin
        if (text_end_i) begin
          push_o              = 1'b1;
          entry_o.first.kind  = KIND_DONE;
        end else if (data_byte_i != CH_N) begin
          push_o        = 1'b1;
          entry_o.first = mk_err(ERR_N, line_c, col_c);
        end
      end else if (is_digit) begin
        push_o = 1'b0;
      end else if (!eff_seen) begin
        push_o        = 1'b1;
        entry_o.first = mk_err(ERR_NUMBER, eff_line, eff_col);
      end else if (eff_ph == PH_HDR_H || eff_ph == PH_VH) begin
        // Record first, then the end-of-line check on the same byte
        push_o = 1'b1;
        if (eff_ph == PH_HDR_H) begin
          entry_o.first.kind   = KIND_HEADER;
          entry_o.first.width  = OUT_W'(h1_q);
          entry_o.first.height = OUT_W'(eff_acc);
        end else begin
          entry_o.first.kind     = KIND_VIEW;
          entry_o.first.ordinal  = OUT_W'(eff_vc);
          entry_o.first.pos_x    = OUT_W'(h1_q);
          entry_o.first.pos_y    = OUT_W'(h2_q);
          entry_o.first.width    = OUT_W'(h3_q);
          entry_o.first.height   = OUT_W'(eff_acc);
          entry_o.first.mismatch = (hl_q != eff_vc);
        end
        if (text_end_i) begin
          entry_o.two         = 1'b1;
          entry_o.second.kind = KIND_DONE;
        end else if (!is_nl) begin
          entry_o.two    = 1'b1;
          entry_o.second = mk_err(ERR_NEWLINE, line_c, col_c);
        end
      end else if (!sep_ok) begin
        push_o        = 1'b1;
        entry_o.first = mk_err(sep_code, line_c, col_c);
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q   <= PH_HDR_W;
      acc_q  <= '0;
      seen_q <= 1'b0;
      line_q <= VALUE_BITS'(1);
      col_q  <= VALUE_BITS'(1);
      vc_q   <= VALUE_BITS'(1);
      fin_q  <= 1'b0;
    end else if (accept_i) begin
      ph_q   <= ph_d;
      acc_q  <= acc_d;
      seen_q <= seen_d;
      line_q <= line_d;
      col_q  <= col_d;
      vc_q   <= vc_d;
      fin_q  <= fin_d;
    end
  end

  // Held numbers, always written before they are read
  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      h1_q <= h1_d;
      h2_q <= h2_d;
      h3_q <= h3_d;
      hl_q <= hl_d;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/vltp_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vltp_queue
// Short entry queue between the front and back parts.
// ----------------------------------------------------------------------------
module vltp_queue (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire vltp_pkg::entry_t entry_i,
  input  wire logic             pop_i,
  output vltp_pkg::entry_t      head_o,
  output vltp_pkg::q_stat_t     stat_o
);
  import vltp_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
    next_ptr = (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  entry_t        slot_q [QUEUE_DEPTH];
  logic [PW-1:0] wr_q, rd_q;
  logic [CW-1:0] cnt_q, cnt_d;

  assign head_o       = slot_q[rd_q];
  assign stat_o.full  = (cnt_q == CW'(QUEUE_DEPTH));
  assign stat_o.empty = (cnt_q == '0);

  // Occupancy
  always_comb begin
    case ({push_i, pop_i})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= next_ptr(wr_q);
      if (pop_i)  rd_q <= next_ptr(rd_q);
      cnt_q <= cnt_d;
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= entry_i;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/vltp_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vltp_back
// Takes entries from the queue and presents their records one per cycle while
// not stalled, through an output register marking each entry's last record.
// ----------------------------------------------------------------------------
module vltp_back (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire vltp_pkg::entry_t  head_i,
  input  wire vltp_pkg::q_stat_t stat_i,
  output logic                   pop_o,
  input  wire logic              out_stall_i,
  output logic                   out_valid_o,
  output vltp_pkg::rec_t         out_rec_o,
  output logic                   out_last_o
);
  import vltp_pkg::*;

  logic valid_q;
  logic sel_q, sel_d;
  rec_t rec_q;
  logic last_q;
  logic load, take, last_sel;

  // Output register is free when empty or being taken
  assign load     = !valid_q || !out_stall_i;
  assign take     = load && !stat_i.empty;
  assign last_sel = !head_i.two || sel_q;
  assign pop_o    = take && last_sel;
  assign sel_d    = take ? (head_i.two && !sel_q) : sel_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      sel_q   <= 1'b0;
    end else begin
      if (load) valid_q <= !stat_i.empty;
      sel_q <= sel_d;
    end
  end

  // Record payload
  always_ff @(posedge clk_i) begin
    if (take) begin
      rec_q  <= sel_q ? head_i.second : head_i.first;
      last_q <= last_sel;
    end
  end

  assign out_valid_o = valid_q;
  assign out_rec_o   = rec_q;
  assign out_last_o  = last_q;

endmodule

`default_nettype wire

// ===== hw/rtl/view_layout_text_parser_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// view_layout_text_parser_unit
// Byte-stream parser for view layout text: header and view records, done,
// or a syntax error with line and column.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                | payload
//  in      | input     | in_valid_i / in_stall_o  | data_byte, text_end, restart
//  out     | output    | out_valid_o / out_stall_i| record fields, last_of_run
//
// One byte request is taken per cycle while in_stall_o is low; the front
// part updates the grammar state in that cycle. Records leave one per cycle
// while out_stall_i is low, so a request that ends a record and also fails
// or finishes yields two output records. A request's first record passes
// through the queue and then the output register. in_stall_o rises only
// while the two-entry queue is full. Reset returns the parser to the header
// width; restart_i does the same for the request that carries it.
// ----------------------------------------------------------------------------
module view_layout_text_parser_unit #(
  parameter int VALUE_BITS = vltp_pkg::VALUE_BITS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        text_end_i,
  input  wire logic        restart_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [1:0]       record_kind_o,
  output logic [15:0]      view_ordinal_o,
  output logic [15:0]      pos_x_o,
  output logic [15:0]      pos_y_o,
  output logic [15:0]      area_width_o,
  output logic [15:0]      area_height_o,
  output logic             label_mismatch_o,
  output logic [2:0]       error_code_o,
  output logic [15:0]      error_line_o,
  output logic [15:0]      error_column_o,
  output logic             last_of_run_o
);
  import vltp_pkg::*;

  logic    accept;
  logic    push, pop;
  entry_t  entry, head;
  q_stat_t stat;
  rec_t    rec;

  assign in_stall_o = stat.full;
  assign accept     = in_valid_i && !stat.full;

  vltp_front #(
    .VALUE_BITS(VALUE_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .data_byte_i  (data_byte_i),
    .text_end_i   (text_end_i),
    .restart_i    (restart_i),
    .push_o       (push),
    .entry_o      (entry)
  );

  vltp_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .entry_i(entry),
    .pop_i  (pop),
    .head_o (head),
    .stat_o (stat)
  );

  vltp_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_i     (head),
    .stat_i     (stat),
    .pop_o      (pop),
    .out_stall_i(out_stall_i),
    .out_valid_o(out_valid_o),
    .out_rec_o  (rec),
    .out_last_o (last_of_run_o)
  );

  // Record fields onto ports
  assign record_kind_o    = rec.kind;
  assign view_ordinal_o   = rec.ordinal;
  assign pos_x_o          = rec.pos_x;
  assign pos_y_o          = rec.pos_y;
  assign area_width_o     = rec.width;
  assign area_height_o    = rec.height;
  assign label_mismatch_o = rec.mismatch;
  assign error_code_o     = rec.code;
  assign error_line_o     = rec.line;
  assign error_column_o   = rec.column;

endmodule

`default_nettype wire

// ===== hw/rtl/vltp_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vltp_checker
// Port-level checks for the view layout text parser, bound to the top level.
// ----------------------------------------------------------------------------
module vltp_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [1:0]  record_kind_o,
  input wire logic [15:0] view_ordinal_o,
  input wire logic [15:0] pos_x_o,
  input wire logic [15:0] pos_y_o,
  input wire logic [15:0] area_width_o,
  input wire logic [15:0] area_height_o,
  input wire logic        label_mismatch_o,
  input wire logic [2:0]  error_code_o,
  input wire logic [15:0] error_line_o,
  input wire logic [15:0] error_column_o,
  input wire logic        last_of_run_o
);
  import vltp_pkg::*;

  // A stalled record holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(record_kind_o)
      && $stable(last_of_run_o) && $stable(error_column_o))
  else $error("stalled record changed");

  // Done and error always close the run of a request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (record_kind_o == KIND_DONE || record_kind_o == KIND_ERROR)
      |-> last_of_run_o)
  else $error("terminal record not last of run");

  // Errors carry no geometry
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && record_kind_o == KIND_ERROR
      |-> pos_x_o == 16'd0 && pos_y_o == 16'd0 && area_width_o == 16'd0
          && area_height_o == 16'd0 && view_ordinal_o == 16'd0 && !label_mismatch_o)
  else $error("error record with geometry");

  // Header and view records carry no error position
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (record_kind_o == KIND_HEADER || record_kind_o == KIND_VIEW)
      |-> error_code_o == 3'd0 && error_line_o == 16'd0 && error_column_o == 16'd0)
  else $error("record carries error position");

endmodule

bind view_layout_text_parser_unit vltp_checker u_vltp_checker (.*);

`default_nettype wire
